// ===== rtl/srtf_process_scheduler_assert.svh =====
// assertion macros for the srtf process scheduler
// expects clk and rst_n in the scope where a macro is used
`ifndef SRTF_PROCESS_SCHEDULER_ASSERT_SVH
`define SRTF_PROCESS_SCHEDULER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SRTF_ASSERT_HOLD(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/srtf_pkg.sv =====
// shared types and constants for the srtf process scheduler
// no dependencies
`default_nettype none

package srtf_pkg;

  // fixed field widths of the transaction payloads
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int FIELD_W = 12;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 5;
  localparam int COUNT_W = 5;

  // opcodes of an input transaction
  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DEC,
    ST_TAT,
    ST_WAIT,
    ST_OUT
  } state_t;

  // write controls from the sequencer to the slot tables
  typedef struct packed {
    logic load_we;
    logic rem_we;
    logic restart;
  } tbl_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/srtf_process_scheduler.sv =====
// Preemptive shortest-remaining-time-first scheduler. A load or restart transaction is taken
// in the idle state and gives no result; the block is ready again on the next cycle. A tick
// transaction scans the n slots in use (n = process_count, capped at MAX_PROCS) one slot per
// cycle through the single read port of the slot memories and the shared subtractor, then
// decrements the winner, computes turnaround and waiting through the same subtractor when the
// winner completes, and loads the output register once it is free; an idle tick goes straight
// from the scan to the output register. in_stall is high throughout; the result sits in an
// output register, so the next transaction is accepted while it waits. Remaining times reset
// to zero through per-slot flag bits, and a restart reloads them from the bursts by the same
// flags, so there is no sweep.
// depends on srtf_pkg, srtf_tables, srtf_sub_unit and srtf_process_scheduler_assert.svh
`default_nettype none

`include "srtf_process_scheduler_assert.svh"

module srtf_process_scheduler #(
  parameter int MAX_PROCS = 16,
  parameter int TIME_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration channel
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [srtf_pkg::CFG_W-1:0]   cfg_process_count,
  // input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [srtf_pkg::OP_W-1:0]    in_opcode,
  input  wire logic [srtf_pkg::SLOT_W-1:0]  in_slot,
  input  wire logic [srtf_pkg::FIELD_W-1:0] in_arrival,
  input  wire logic [srtf_pkg::FIELD_W-1:0] in_burst,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [srtf_pkg::OUT_W-1:0]        out_tick_start,
  output logic                              out_idle,
  output logic [srtf_pkg::SLOT_W-1:0]       out_chosen,
  output logic                              out_finished,
  output logic [srtf_pkg::OUT_W-1:0]        out_completion_time,
  output logic [srtf_pkg::OUT_W-1:0]        out_turnaround,
  output logic [srtf_pkg::OUT_W-1:0]        out_waiting,
  output logic                              out_all_done
);

  localparam int FW   = srtf_pkg::FIELD_W;
  localparam int OW   = srtf_pkg::OUT_W;
  localparam int CW   = srtf_pkg::COUNT_W;
  localparam int IDXW = $clog2(MAX_PROCS);
  localparam int NW   = $clog2(MAX_PROCS + 1);
  localparam int LW   = (NW > srtf_pkg::CFG_W) ? NW : srtf_pkg::CFG_W;
  localparam int UW   = (TIME_BITS > FW) ? TIME_BITS : FW;

  srtf_pkg::state_t            state_r, state_nxt;
  logic [srtf_pkg::CFG_W-1:0]  pc_r, pc_nxt;
  logic [TIME_BITS-1:0]        time_r, time_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [LW-1:0]               cnt_r, cnt_nxt;
  logic                        ev_vld_r, ev_vld_nxt;
  logic [IDXW-1:0]             ev_idx_r, ev_idx_nxt;
  logic                        found_r, found_nxt;
  logic                        done_r, done_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [IDXW-1:0]             best_idx_r, best_idx_nxt;
  logic [FW-1:0]               best_rem_r, best_rem_nxt;
  logic [FW-1:0]               best_arr_r, best_arr_nxt;
  logic [FW-1:0]               best_burst_r, best_burst_nxt;
  logic [TIME_BITS-1:0]        start_r, start_nxt;
  logic [UW-1:0]               tat_r, tat_nxt;
  logic [UW-1:0]               wt_r, wt_nxt;
  logic [OW-1:0]               out_tick_start_r, out_tick_start_nxt;
  logic                        out_idle_r, out_idle_nxt;
  logic [srtf_pkg::SLOT_W-1:0] out_chosen_r, out_chosen_nxt;
  logic                        out_finished_r, out_finished_nxt;
  logic [OW-1:0]               out_completion_r, out_completion_nxt;
  logic [OW-1:0]               out_turnaround_r, out_turnaround_nxt;
  logic [OW-1:0]               out_waiting_r, out_waiting_nxt;
  logic                        out_all_done_r, out_all_done_nxt;

  logic                        in_accept;
  logic                        slot_ok;
  logic [LW-1:0]               pc_ext;
  logic [LW-1:0]               n_ext;
  logic [TIME_BITS-1:0]        time_inc;
  logic                        elig;

  srtf_pkg::tbl_ctrl_t         tbl_ctrl;
  logic [IDXW-1:0]             tbl_wr_idx;
  logic [FW-1:0]               tbl_wr_rem;
  logic [IDXW-1:0]             tbl_rd_idx;
  logic [FW-1:0]               tbl_arrival;
  logic [FW-1:0]               tbl_burst;
  logic [FW-1:0]               tbl_remaining;

  logic [UW-1:0]               sub_a;
  logic [UW-1:0]               sub_b;
  logic [UW-1:0]               sub_diff;
  logic                        sub_borrow;

  // slot tables
  srtf_tables #(
    .MAX_PROCS (MAX_PROCS),
    .IDXW      (IDXW)
  ) u_tables (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (tbl_ctrl),
    .wr_idx       (tbl_wr_idx),
    .wr_arrival   (in_arrival),
    .wr_burst     (in_burst),
    .wr_remaining (tbl_wr_rem),
    .rd_idx       (tbl_rd_idx),
    .rd_arrival   (tbl_arrival),
    .rd_burst     (tbl_burst),
    .rd_remaining (tbl_remaining)
  );

  // shared subtractor
  srtf_sub_unit #(
    .W (UW)
  ) u_sub (
    .op_a   (sub_a),
    .op_b   (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != srtf_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  // slots in use, capped at the table depth
  assign pc_ext  = LW'(pc_r);
  assign n_ext   = (pc_ext > LW'(MAX_PROCS)) ? LW'(MAX_PROCS) : pc_ext;
  assign slot_ok = int'(in_slot) < MAX_PROCS;

  // saturating time advance
  assign time_inc = (time_r == '1) ? time_r : time_r + TIME_BITS'(1);

  // slot under evaluation wins if arrived, has work and beats the best so far
  assign elig = !sub_borrow && (tbl_remaining != '0) &&
                (!found_r || (tbl_remaining < best_rem_r));

  // sequencer
  always_comb begin
    state_nxt          = state_r;
    pc_nxt             = pc_r;
    time_nxt           = time_r;
    count_nxt          = count_r;
    cnt_nxt            = cnt_r;
    ev_vld_nxt         = 1'b0;
    ev_idx_nxt         = ev_idx_r;
    found_nxt          = found_r;
    done_nxt           = done_r;
    best_idx_nxt       = best_idx_r;
    best_rem_nxt       = best_rem_r;
    best_arr_nxt       = best_arr_r;
    best_burst_nxt     = best_burst_r;
    start_nxt          = start_r;
    tat_nxt            = tat_r;
    wt_nxt             = wt_r;
    out_valid_nxt      = out_valid_r && out_stall;
    out_tick_start_nxt = out_tick_start_r;
    out_idle_nxt       = out_idle_r;
    out_chosen_nxt     = out_chosen_r;
    out_finished_nxt   = out_finished_r;
    out_completion_nxt = out_completion_r;
    out_turnaround_nxt = out_turnaround_r;
    out_waiting_nxt    = out_waiting_r;
    out_all_done_nxt   = out_all_done_r;
    tbl_ctrl           = '0;
    tbl_wr_idx         = IDXW'(in_slot);
    tbl_wr_rem         = sub_diff[FW-1:0];
    tbl_rd_idx         = cnt_r[IDXW-1:0];
    sub_a              = UW'(time_r);
    sub_b              = UW'(tbl_arrival);

    // register write
    if (cfg_valid && cfg_ready) begin
      pc_nxt = cfg_process_count;
    end

    case (state_r)
      srtf_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_opcode)
            srtf_pkg::OP_LOAD: begin
              tbl_ctrl.load_we = slot_ok;
            end
            srtf_pkg::OP_TICK: begin
              cnt_nxt   = '0;
              found_nxt = 1'b0;
              done_nxt  = 1'b0;
              start_nxt = time_r;
              state_nxt = srtf_pkg::ST_SCAN;
            end
            srtf_pkg::OP_RESTART: begin
              tbl_ctrl.restart = 1'b1;
              time_nxt         = '0;
              count_nxt        = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // one slot read and one slot evaluated each cycle
      srtf_pkg::ST_SCAN: begin
        if (ev_vld_r && elig) begin
          found_nxt      = 1'b1;
          best_idx_nxt   = ev_idx_r;
          best_rem_nxt   = tbl_remaining;
          best_arr_nxt   = tbl_arrival;
          best_burst_nxt = tbl_burst;
        end
        if (cnt_r < n_ext) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = cnt_r[IDXW-1:0];
          cnt_nxt    = cnt_r + LW'(1);
        end else begin
          time_nxt  = time_inc;
          state_nxt = found_nxt ? srtf_pkg::ST_DEC : srtf_pkg::ST_OUT;
        end
      end

      // run the winner for one unit
      srtf_pkg::ST_DEC: begin
        sub_a           = UW'(best_rem_r);
        sub_b           = UW'(1);
        tbl_ctrl.rem_we = 1'b1;
        tbl_wr_idx      = best_idx_r;
        if (sub_diff[FW-1:0] == '0) begin
          done_nxt  = 1'b1;
          count_nxt = (count_r == '1) ? count_r : count_r + CW'(1);
          state_nxt = srtf_pkg::ST_TAT;
        end else begin
          state_nxt = srtf_pkg::ST_OUT;
        end
      end

      // turnaround = completion - arrival, floored at zero
      srtf_pkg::ST_TAT: begin
        sub_a     = UW'(time_r);
        sub_b     = UW'(best_arr_r);
        tat_nxt   = sub_borrow ? '0 : sub_diff;
        state_nxt = srtf_pkg::ST_WAIT;
      end

      // waiting = turnaround - burst, floored at zero
      srtf_pkg::ST_WAIT: begin
        sub_a     = tat_r;
        sub_b     = UW'(best_burst_r);
        wt_nxt    = sub_borrow ? '0 : sub_diff;
        state_nxt = srtf_pkg::ST_OUT;
      end

      // load the output register once it is free
      srtf_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt      = 1'b1;
          out_tick_start_nxt = OW'(start_r);
          out_idle_nxt       = !found_r;
          out_chosen_nxt     = found_r ? srtf_pkg::SLOT_W'(best_idx_r) : '0;
          out_finished_nxt   = done_r;
          out_completion_nxt = done_r ? OW'(time_r) : '0;
          out_turnaround_nxt = done_r ? OW'(tat_r) : '0;
          out_waiting_nxt    = done_r ? OW'(wt_r) : '0;
          out_all_done_nxt   = (LW'(count_r) == n_ext);
          state_nxt          = srtf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = srtf_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srtf_pkg::ST_IDLE;
      pc_r        <= srtf_pkg::CFG_W'(1);
      time_r      <= '0;
      count_r     <= '0;
      cnt_r       <= '0;
      ev_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      time_r      <= time_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      found_r     <= found_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ev_idx_r         <= ev_idx_nxt;
    best_idx_r       <= best_idx_nxt;
    best_rem_r       <= best_rem_nxt;
    best_arr_r       <= best_arr_nxt;
    best_burst_r     <= best_burst_nxt;
    start_r          <= start_nxt;
    tat_r            <= tat_nxt;
    wt_r             <= wt_nxt;
    out_tick_start_r <= out_tick_start_nxt;
    out_idle_r       <= out_idle_nxt;
    out_chosen_r     <= out_chosen_nxt;
    out_finished_r   <= out_finished_nxt;
    out_completion_r <= out_completion_nxt;
    out_turnaround_r <= out_turnaround_nxt;
    out_waiting_r    <= out_waiting_nxt;
    out_all_done_r   <= out_all_done_nxt;
  end

  // result ports
  assign out_valid           = out_valid_r;
  assign out_tick_start      = out_tick_start_r;
  assign out_idle            = out_idle_r;
  assign out_chosen          = out_chosen_r;
  assign out_finished        = out_finished_r;
  assign out_completion_time = out_completion_r;
  assign out_turnaround      = out_turnaround_r;
  assign out_waiting         = out_waiting_r;
  assign out_all_done        = out_all_done_r;

  // checks
  `SRTF_ASSERT_NEXT(a_tick_starts_scan, in_accept && in_opcode == srtf_pkg::OP_TICK, state_r == srtf_pkg::ST_SCAN, "tick transaction did not start a scan")
  `SRTF_ASSERT_HOLD(a_scan_bound, state_r == srtf_pkg::ST_SCAN, cnt_r <= n_ext, "scan ran past the slots in use")
  `SRTF_ASSERT_HOLD(a_dec_has_winner, state_r == srtf_pkg::ST_DEC, found_r && best_rem_r != '0, "decrement without a runnable winner")
  `SRTF_ASSERT_NEXT(a_zero_rem_done, state_r == srtf_pkg::ST_DEC && sub_diff[FW-1:0] == '0, done_r && state_r == srtf_pkg::ST_TAT, "completion not recorded")
  `SRTF_ASSERT_HOLD(a_finish_not_idle, out_valid_r, !(out_finished_r && out_idle_r), "idle tick reported a completion")

endmodule

`default_nettype wire

// ===== rtl/srtf_sub_unit.sv =====
// shared subtractor used for the arrival compare and every difference of a tick
// no dependencies
`default_nettype none

module srtf_sub_unit #(
  parameter int W = 16
) (
  input  wire logic [W-1:0] op_a,
  input  wire logic [W-1:0] op_b,
  output logic      [W-1:0] diff,
  output logic              borrow
);

  // a minus b with borrow out, borrow set when b exceeds a
  assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};

endmodule

`default_nettype wire

// ===== rtl/srtf_tables.sv =====
// per-slot arrival, burst and remaining-time memories with registered read
// depends on srtf_pkg
`default_nettype none

module srtf_tables #(
  parameter int MAX_PROCS = 16,
  parameter int IDXW      = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire srtf_pkg::tbl_ctrl_t          ctrl,
  input  wire logic [IDXW-1:0]              wr_idx,
  input  wire logic [srtf_pkg::FIELD_W-1:0] wr_arrival,
  input  wire logic [srtf_pkg::FIELD_W-1:0] wr_burst,
  input  wire logic [srtf_pkg::FIELD_W-1:0] wr_remaining,
  input  wire logic [IDXW-1:0]              rd_idx,
  output logic      [srtf_pkg::FIELD_W-1:0] rd_arrival,
  output logic      [srtf_pkg::FIELD_W-1:0] rd_burst,
  output logic      [srtf_pkg::FIELD_W-1:0] rd_remaining
);

  localparam int FW = srtf_pkg::FIELD_W;

  logic [2*FW-1:0]      ab_mem [MAX_PROCS];
  logic [FW-1:0]        rem_mem [MAX_PROCS];
  logic [2*FW-1:0]      ab_q;
  logic [FW-1:0]        rem_q;
  logic [IDXW-1:0]      rd_idx_q;
  logic [MAX_PROCS-1:0] rem_valid_r;
  logic [MAX_PROCS-1:0] rem_valid_nxt;
  logic [MAX_PROCS-1:0] rem_src_r;
  logic [MAX_PROCS-1:0] rem_src_nxt;

  // arrival and burst memory, one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.load_we) begin
      ab_mem[wr_idx] <= {wr_arrival, wr_burst};
    end
    ab_q <= ab_mem[rd_idx];
  end

  // remaining-time memory
  always_ff @(posedge clk) begin
    if (ctrl.rem_we) begin
      rem_mem[wr_idx] <= wr_remaining;
    end
    rem_q    <= rem_mem[rd_idx];
    rd_idx_q <= rd_idx;
  end

  // entry flags: not valid reads as zero, source set reads the burst instead
  always_comb begin
    rem_valid_nxt = rem_valid_r;
    rem_src_nxt   = rem_src_r;
    if (ctrl.restart) begin
      rem_valid_nxt = '1;
      rem_src_nxt   = '1;
    end else if (ctrl.load_we) begin
      rem_valid_nxt[wr_idx] = 1'b1;
      rem_src_nxt[wr_idx]   = 1'b1;
    end else if (ctrl.rem_we) begin
      rem_valid_nxt[wr_idx] = 1'b1;
      rem_src_nxt[wr_idx]   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_valid_r <= '0;
      rem_src_r   <= '0;
    end else begin
      rem_valid_r <= rem_valid_nxt;
      rem_src_r   <= rem_src_nxt;
    end
  end

  // read data with the flags applied
  assign rd_arrival   = ab_q[2*FW-1:FW];
  assign rd_burst     = ab_q[FW-1:0];
  assign rd_remaining = !rem_valid_r[rd_idx_q] ? '0 :
                        (rem_src_r[rd_idx_q] ? ab_q[FW-1:0] : rem_q);

endmodule

`default_nettype wire

// ===== sim/tb_srtf_process_scheduler.sv =====
// self-checking testbench for the srtf process scheduler: clocked driver and monitor,
// a scheduling predictor with its own slot tables, and phased stimulus across process counts
// depends on srtf_pkg and the srtf_process_scheduler rtl
`default_nettype none

module tb_srtf_process_scheduler;

  localparam int OP_W    = srtf_pkg::OP_W;
  localparam int SLOT_W  = srtf_pkg::SLOT_W;
  localparam int FIELD_W = srtf_pkg::FIELD_W;
  localparam int OUT_W   = srtf_pkg::OUT_W;
  localparam int CFG_W   = srtf_pkg::CFG_W;
  localparam int COUNT_W = srtf_pkg::COUNT_W;

  localparam int NSLOT = 16;
  localparam logic [OUT_W-1:0] TIME_TOP = '1;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 200;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] arrival;
    logic [FIELD_W-1:0] burst;
  } sched_item_t;

  typedef struct packed {
    logic [OUT_W-1:0]  tick_start;
    logic              idle;
    logic [SLOT_W-1:0] chosen;
    logic              finished;
    logic [OUT_W-1:0]  completion_time;
    logic [OUT_W-1:0]  turnaround;
    logic [OUT_W-1:0]  waiting;
    logic              all_done;
  } tick_result_t;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_process_count = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode = '0;
  logic [SLOT_W-1:0]    in_slot = '0;
  logic [FIELD_W-1:0]   in_arrival = '0;
  logic [FIELD_W-1:0]   in_burst = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUT_W-1:0]     out_tick_start;
  logic                 out_idle;
  logic [SLOT_W-1:0]    out_chosen;
  logic                 out_finished;
  logic [OUT_W-1:0]     out_completion_time;
  logic [OUT_W-1:0]     out_turnaround;
  logic [OUT_W-1:0]     out_waiting;
  logic                 out_all_done;

  srtf_process_scheduler u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_process_count   (cfg_process_count),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_slot             (in_slot),
    .in_arrival          (in_arrival),
    .in_burst            (in_burst),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tick_start      (out_tick_start),
    .out_idle            (out_idle),
    .out_chosen          (out_chosen),
    .out_finished        (out_finished),
    .out_completion_time (out_completion_time),
    .out_turnaround      (out_turnaround),
    .out_waiting         (out_waiting),
    .out_all_done        (out_all_done)
  );

  // clock
  always #5 clk = ~clk;

  // scheduler state as predicted
  logic [FIELD_W-1:0] sch_arrival [NSLOT];
  logic [FIELD_W-1:0] sch_burst [NSLOT];
  logic [FIELD_W-1:0] sch_remaining [NSLOT];
  logic [OUT_W-1:0]   sch_time;
  logic [COUNT_W-1:0] sch_done;
  logic [CFG_W-1:0]   sch_procs;

  sched_item_t  job_q[$];
  tick_result_t expected_ticks_q[$];

  int err_cnt = 0;
  int accepted_n = 0;
  int results_n = 0;
  int finished_n = 0;
  int cfg_writes_n = 0;
  bit quiet = 1'b0;
  int hold_reqs = 0;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // apply one accepted transaction to the predicted scheduler state
  task automatic schedule_step(input sched_item_t it);
    tick_result_t r;
    int n;
    int best;
    bit found;
    logic [OUT_W-1:0] tat;
    r = '0;
    best = 0;
    found = 1'b0;
    case (it.opcode)
      srtf_pkg::OP_LOAD: begin
        sch_arrival[it.slot] = it.arrival;
        sch_burst[it.slot] = it.burst;
        sch_remaining[it.slot] = it.burst;
      end
      srtf_pkg::OP_RESTART: begin
        sch_time = '0;
        sch_done = '0;
        for (int i = 0; i < NSLOT; i++) sch_remaining[i] = sch_burst[i];
      end
      srtf_pkg::OP_TICK: begin
        n = (sch_procs > NSLOT) ? NSLOT : int'(sch_procs);
        // least remaining time among arrived slots, lowest index on a tie
        for (int i = 0; i < n; i++) begin
          if ({4'd0, sch_arrival[i]} <= sch_time && sch_remaining[i] != 0 &&
              (!found || sch_remaining[i] < sch_remaining[best])) begin
            found = 1'b1;
            best = i;
          end
        end
        r.tick_start = sch_time;
        if (sch_time != TIME_TOP) sch_time = sch_time + 1'b1;
        r.idle = !found;
        if (found) begin
          r.chosen = best[SLOT_W-1:0];
          sch_remaining[best] = sch_remaining[best] - 1'b1;
          if (sch_remaining[best] == 0) begin
            r.finished = 1'b1;
            if (sch_done != COUNT_TOP) sch_done = sch_done + 1'b1;
            r.completion_time = sch_time;
            tat = (sch_time > sch_arrival[best]) ? sch_time - sch_arrival[best] : '0;
            r.turnaround = tat;
            r.waiting = (tat > sch_burst[best]) ? tat - sch_burst[best] : '0;
          end
        end
        r.all_done = (int'(sch_done) == n);
        expected_ticks_q.insert(expected_ticks_q.size(), r);
      end
      default: ;
    endcase
  endtask

  // input driver: bursts with random gaps, fed from job_q
  sched_item_t on_port;
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        schedule_step(on_port);
        accepted_n++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 && !quiet) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (job_q.size() > 0) begin
          on_port = job_q.pop_front();
          in_opcode <= on_port.opcode;
          in_slot <= on_port.slot;
          in_arrival <= on_port.arrival;
          in_burst <= on_port.burst;
          in_valid <= 1'b1;
          burst_left = burst_left - 1;
          if (burst_left <= 0 && !quiet) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // compare one result transaction with the oldest expectation
  task automatic check_tick();
    tick_result_t want;
    results_n++;
    if (expected_ticks_q.size() == 0) begin
      report_mismatch($sformatf("result transaction with none expected, tick_start %0d",
                                out_tick_start));
      return;
    end
    want = expected_ticks_q.pop_front();
    if (out_finished === 1'b1) finished_n++;
    check_field("tick_start", out_tick_start, want.tick_start);
    check_field("idle", OUT_W'(out_idle), OUT_W'(want.idle));
    check_field("chosen", OUT_W'(out_chosen), OUT_W'(want.chosen));
    check_field("finished", OUT_W'(out_finished), OUT_W'(want.finished));
    check_field("completion_time", out_completion_time, want.completion_time);
    check_field("turnaround", out_turnaround, want.turnaround);
    check_field("waiting", out_waiting, want.waiting);
    check_field("all_done", OUT_W'(out_all_done), OUT_W'(want.all_done));
  endtask

  // result monitor and receiver stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int mode_left = 0;
  int hold_left = 0;
  int hold_served = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_tick();
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_served != hold_reqs) begin
        hold_served++;
        hold_left = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left = mode_left - 1;
        case (stall_mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  task automatic push_load(input int s, input int a, input int b);
    sched_item_t it;
    it = '{srtf_pkg::OP_LOAD, SLOT_W'(s), FIELD_W'(a), FIELD_W'(b)};
    job_q.insert(job_q.size(), it);
  endtask

  // non-load transaction with random don't-care fields
  task automatic push_op(input logic [OP_W-1:0] op);
    sched_item_t it;
    it = '{op, SLOT_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom)};
    job_q.insert(job_q.size(), it);
  endtask

  // wait until everything sent has been answered, then let the block settle
  task automatic wait_drained();
    do @(negedge clk); while (job_q.size() != 0 || in_valid || expected_ticks_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_procs(input int v);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_process_count <= CFG_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sch_procs = CFG_W'(v);
    cfg_writes_n++;
  endtask

  // mostly well-formed batches (loads, maybe a restart, enough ticks), plus noise
  task automatic gen_random_items(input int target, input int active);
    int made;
    int k;
    int total;
    int top;
    int b;
    made = 0;
    top = (active > NSLOT) ? NSLOT - 1 : ((active < 1) ? 0 : active - 1);
    while (made < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          k = $urandom_range(1, 6);
          total = 0;
          repeat (k) begin
            b = $urandom_range(0, 6);
            push_load(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, top),
                      $urandom_range(0, 15), b);
            total += b;
            made++;
          end
          if ($urandom_range(0, 5) == 0) begin
            push_op(srtf_pkg::OP_RESTART);
            made++;
          end
          repeat (total + $urandom_range(0, 4)) begin
            push_op(srtf_pkg::OP_TICK);
            made++;
          end
        end
        6, 7: begin
          push_load($urandom_range(0, 15), $urandom_range(0, 4095), $urandom_range(0, 4095));
          made++;
        end
        8: begin
          repeat ($urandom_range(1, 10)) begin
            push_op(srtf_pkg::OP_TICK);
            made++;
          end
        end
        default: begin
          push_op(($urandom_range(0, 1) == 0) ? srtf_pkg::OP_RESTART : OP_UNUSED);
          made++;
        end
      endcase
    end
  endtask

  // run limit
  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus phases
  initial begin
    int counts [8];
    int n_now;
    for (int i = 0; i < NSLOT; i++) begin
      sch_arrival[i] = '0;
      sch_burst[i] = '0;
      sch_remaining[i] = '0;
    end
    sch_time = '0;
    sch_done = '0;
    sch_procs = 5'd1;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // one slot at the reset process count: zero burst, run to completion, then idle
    push_load(0, 0, 0);
    push_op(srtf_pkg::OP_TICK);
    push_load(0, 1, 2);
    repeat (4) push_op(srtf_pkg::OP_TICK);
    push_op(OP_UNUSED);

    // all slots: field extremes, two slots with the least burst, restart
    set_procs(16);
    for (int i = 0; i < NSLOT; i++) begin
      push_load(i, (i == 14) ? 4095 : i % 3,
                (i == 15) ? 4095 : ((i == 2 || i == 4) ? 1 : 3 + i));
    end
    push_op(srtf_pkg::OP_RESTART);
    repeat (4) push_op(srtf_pkg::OP_TICK);

    // random phases over several process counts, including zero and above the slot count
    counts = '{16, 31, 5, 1, 17, 0, $urandom_range(2, 15), 16};
    for (int p = 0; p < 8; p++) begin
      set_procs(counts[p]);
      n_now = counts[p];
      if (p == 2) begin
        // sender pauses mid-phase until every result is back
        gen_random_items(65, n_now);
        wait_drained();
        gen_random_items(65, n_now);
      end else begin
        gen_random_items(130, n_now);
      end
      if (p == 0) hold_reqs++;
    end

    // completed count saturation on a single slot
    set_procs(1);
    push_op(srtf_pkg::OP_RESTART);
    repeat (36) begin
      push_load(0, 0, 1);
      push_op(srtf_pkg::OP_TICK);
    end

    // back-to-back traffic, no idling on either side
    quiet = 1'b1;
    set_procs(16);
    for (int i = 0; i < 4; i++) push_load($urandom_range(0, 15), $urandom, $urandom_range(1, 3));
    repeat (30) push_op(srtf_pkg::OP_TICK);
    wait_drained();
    quiet = 1'b0;
    push_op(srtf_pkg::OP_RESTART);
    repeat (10) push_op(srtf_pkg::OP_TICK);

    wait_drained();
    $display("run covered %0d input transactions, %0d tick results, %0d completions",
             accepted_n, results_n, finished_n);
    $display("over %0d process count writes, including completed count saturation",
             cfg_writes_n);
    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
